// File: rtl/nlmf_pkg.sv
// ----------------------------------------------------------------------------
// nlmf_pkg
// Types and constants shared by the newline message byte fifo.
// ----------------------------------------------------------------------------
package nlmf_pkg;

    localparam int CAP_W   = 7;
    localparam int LEN_W   = 4;
    localparam int QUERY_W = 7;
    localparam int BYTE_W  = 8;
    localparam int MSG_LO_W = 64;
    localparam int MSG_HI_W = 56;
    localparam int MSG_W    = MSG_LO_W + MSG_HI_W;

    localparam logic [CAP_W-1:0]  CAP_RESET    = 7'd64;
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SPACE  = 2'd2;

    typedef struct packed {
        logic [1:0]          operation;
        logic [LEN_W-1:0]    msg_len;
        logic [MSG_LO_W-1:0] message_low;
        logic [MSG_HI_W-1:0] message_high;
        logic [QUERY_W-1:0]  space_query;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
        logic              is_empty;
        logic [CAP_W-1:0]  stored_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_POP_READ,
        S_POP_DATA,
        S_RESP
    } ctrl_state_t;

endpackage

// File: rtl/newline_message_byte_fifo.sv
// ----------------------------------------------------------------------------
// newline_message_byte_fifo
// Circular byte queue holding newline-terminated messages, with a
// programmable capacity register.
// ----------------------------------------------------------------------------
// A command takes one transaction on cmd and gives one or more transactions on
// rsp. All bytes move through a single-port byte store with registered read;
// no new command is taken until the last one is through. An add is decoded,
// writes its characters and a closing newline, then offers its response; a
// space check or a rejected command is decoded and answered; a remove is
// decoded, then each popped byte passes read, data and response states.
// cmd_ready is high only while no command is in progress. The capacity
// register is always ready and should be written only while the block is idle.
module newline_message_byte_fifo #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_MSG     = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  nlmf_pkg::cmd_t                cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output nlmf_pkg::rsp_t                rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nlmf_pkg::CAP_W-1:0]    cfg_data
);

    import nlmf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  eff_cap;
    logic              ram_en;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            cap_reg <= cfg_data;
        end
    end

    // zero acts as one, anything past the store depth acts as the depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(QUEUE_DEPTH))
        begin
            eff_cap = CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    nlmf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_MSG     (MAX_MSG)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .eff_cap   (eff_cap),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    nlmf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

// File: rtl/nlmf_ram.sv
// ----------------------------------------------------------------------------
// nlmf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module nlmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nlmf_ctrl.sv
// ----------------------------------------------------------------------------
// nlmf_ctrl
// Sequencer and pointer/count datapath: walks one byte per step through the
// byte store for add and remove, and answers space checks.
// ----------------------------------------------------------------------------
module nlmf_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_MSG     = 15
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  nlmf_pkg::cmd_t                   cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output nlmf_pkg::rsp_t                   rsp,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] eff_cap,
    output logic                             ram_en,
    output logic                             ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   ram_addr,
    output logic [nlmf_pkg::BYTE_W-1:0]      ram_wdata,
    input  logic [nlmf_pkg::BYTE_W-1:0]      ram_rdata
);

    import nlmf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > QUERY_W) ? CNT_W : QUERY_W;

    ctrl_state_t        state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [MSG_W-1:0]   msg_reg, msg_next;
    logic [QUERY_W-1:0] query_reg, query_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    rsp_t               rsp_reg, rsp_next;
    logic               more_reg, more_next;

    logic [CNT_W-1:0]   free_space;
    logic [BYTE_W-1:0]  cur_char;
    logic               stop;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= cap) ? '0 : PTR_W'(n);
    endfunction

    function automatic rsp_t make_rsp(input logic ok, input logic [BYTE_W-1:0] b,
                                      input logic last, input logic [CNT_W-1:0] cnt);
        rsp_t r;
        r.ok           = ok;
        r.out_byte     = b;
        r.last_byte    = last;
        r.is_empty     = (cnt == '0);
        r.stored_count = CAP_W'(cnt);
        return r;
    endfunction

    assign free_space = (count_reg >= eff_cap) ? '0 : eff_cap - count_reg;
    assign cur_char   = msg_reg[BYTE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            more_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            more_reg   <= more_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        len_reg   <= len_next;
        msg_reg   <= msg_next;
        query_reg <= query_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        len_next    = len_reg;
        msg_next    = msg_reg;
        query_next  = query_reg;
        idx_next    = idx_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        rsp_next    = rsp_reg;
        more_next   = more_reg;
        cmd_ready   = 1'b0;
        rsp_valid   = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = wr_ptr_reg;
        ram_wdata   = NEWLINE_CHAR;
        stop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next    = cmd.operation;
                    len_next   = cmd.msg_len;
                    msg_next   = {cmd.message_high, cmd.message_low};
                    query_next = cmd.space_query;
                    idx_next   = '0;
                    more_next  = 1'b0;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                rsp_next   = make_rsp(1'b0, '0, 1'b1, count_reg);
                state_next = S_RESP;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!(len_reg > LEN_W'(MAX_MSG)) &&
                            !(CMP_W'(free_space) < CMP_W'(len_reg) + CMP_W'(1)))
                        begin
                            state_next = S_ADD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_POP_READ;
                        end
                    end
                    OP_SPACE:
                    begin
                        rsp_next = make_rsp(CMP_W'(query_reg) <= CMP_W'(free_space),
                                            '0, 1'b1, count_reg);
                    end
                    default:
                    begin
                        rsp_next = make_rsp(1'b0, '0, 1'b1, count_reg);
                    end
                endcase
            end

            S_ADD:
            begin
                ram_en      = 1'b1;
                ram_we      = 1'b1;
                ram_addr    = wr_ptr_reg;
                wr_ptr_next = step_ptr(wr_ptr_reg, eff_cap);
                count_next  = count_reg + CNT_W'(1);
                // characters until length reached or an embedded newline, then newline
                if ((idx_reg < len_reg) && (cur_char != NEWLINE_CHAR))
                begin
                    ram_wdata = cur_char;
                    msg_next  = msg_reg >> BYTE_W;
                    idx_next  = idx_reg + LEN_W'(1);
                end
                else
                begin
                    ram_wdata  = NEWLINE_CHAR;
                    rsp_next   = make_rsp(1'b1, '0, 1'b1, count_reg + CNT_W'(1));
                    state_next = S_RESP;
                end
            end

            S_POP_READ:
            begin
                ram_en     = 1'b1;
                ram_addr   = rd_ptr_reg;
                state_next = S_POP_DATA;
            end

            S_POP_DATA:
            begin
                rd_ptr_next = step_ptr(rd_ptr_reg, eff_cap);
                count_next  = count_reg - CNT_W'(1);
                stop        = (ram_rdata == NEWLINE_CHAR) || (count_next == '0) ||
                              (idx_reg == LEN_W'(MAX_MSG));
                idx_next    = idx_reg + LEN_W'(1);
                rsp_next    = make_rsp(1'b1, ram_rdata, stop, count_next);
                more_next   = !stop;
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = more_reg ? S_POP_READ : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule
